FILE: rtl/pfs_pkg.sv
// pfs_pkg: shared types and constants of the portal funnel path smoother
`default_nettype none
package pfs_pkg;
    localparam int COORD_W = 16;
    localparam int VEC_W = COORD_W + 1;
    localparam int PROD_W = 2 * VEC_W;
    localparam int NEAR_LIM = 16;
    localparam int NEAR_SQ = 256;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_PORTAL = 1'b1;

    typedef enum logic [1:0] {
        SIDE_RIGHT = 2'd0,
        SIDE_LEFT = 2'd1,
        SIDE_NEAR = 2'd3
    } side_t;

    typedef struct packed {
        logic cmd;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic final_portal;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic path_end;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } portal_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } vec_t;
endpackage
`default_nettype wire

FILE: rtl/portal_funnel_path_smoother_unit.sv
// portal_funnel_path_smoother_unit: top level of the funnel path smoother
// A query beat sets start and end points; portal beats are stored one per cycle
// with busy low. The beat with final_portal set starts the scan and busy stays
// high until the end point leaves. The scan emits the start point, each turning
// point and the end point (path_end set), one beat per strobe; the receiver
// cannot stall. Every side test runs on one shared multiplier; a portal passes
// through the fetch and load states and then takes 1 to 5 side tests, and a broken
// funnel rescans from the portal after the corner.
`default_nettype none
module portal_funnel_path_smoother_unit #(
    parameter int MAX_PORTALS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire pfs_pkg::item_t   item,
    output logic                  busy,
    output pfs_pkg::result_t      result,
    output logic                  strobe
);
    localparam int IDX_W = (MAX_PORTALS > 1) ? $clog2(MAX_PORTALS) : 1;
    localparam int CNT_W = $clog2(MAX_PORTALS + 1);
    localparam int CW = pfs_pkg::COORD_W;
    localparam int VW = pfs_pkg::VEC_W;

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b000000000001,
        ST_EMIT_START = 12'b000000000010,
        ST_FETCH      = 12'b000000000100,
        ST_LOAD       = 12'b000000001000,
        ST_ORDER      = 12'b000000010000,
        ST_SIDE_A     = 12'b000000100000,
        ST_SIDE_D     = 12'b000001000000,
        ST_SIDE_C     = 12'b000010000000,
        ST_SIDE_B     = 12'b000100000000,
        ST_END_L      = 12'b001000000000,
        ST_END_R      = 12'b010000000000,
        ST_EMIT_END   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next, i_reg, i_next;
    logic [IDX_W-1:0] lidx_reg, lidx_next, ridx_reg, ridx_next;
    logic signed [CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CW-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [CW-1:0] apx_reg, apx_next, apy_reg, apy_next;
    pfs_pkg::vec_t lv_reg, lv_next, rv_reg, rv_next, c0_reg, c0_next, c1_reg, c1_next;
    pfs_pkg::vec_t op_o_reg, op_o_next, op_t_reg, op_t_next;
    pfs_pkg::vec_t nc0, nc1, ev;
    logic fresh_reg, fresh_next, go_reg, go_next;
    pfs_pkg::side_t a_reg, a_next, d_reg, d_next;
    pfs_pkg::result_t res_reg, res_next;
    logic strobe_reg, strobe_next;
    logic we;
    logic [IDX_W-1:0] raddr;
    pfs_pkg::portal_t wdata, rdata;
    logic side_done;
    pfs_pkg::side_t side_code;
    logic signed [CW-1:0] lpx, lpy, rpx, rpy;

    pfs_ram #(
        .WIDTH ($bits(pfs_pkg::portal_t)),
        .DEPTH (MAX_PORTALS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfs_side u_side (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .o     (op_o_reg),
        .t     (op_t_reg),
        .done  (side_done),
        .code  (side_code)
    );

    always_comb
    begin
        wdata.ax = item.ax;
        wdata.ay = item.ay;
        wdata.bx = item.bx;
        wdata.by = item.by;
        we = (state_reg == ST_IDLE) && start && (item.cmd == pfs_pkg::CMD_PORTAL)
            && (count_reg < CNT_W'(MAX_PORTALS));
        raddr = i_reg[IDX_W-1:0];
        busy = (state_reg != ST_IDLE);
        result = res_reg;
        strobe = strobe_reg;
        lpx = CW'(lv_reg.x + VW'(apx_reg));
        lpy = CW'(lv_reg.y + VW'(apy_reg));
        rpx = CW'(rv_reg.x + VW'(apx_reg));
        rpy = CW'(rv_reg.y + VW'(apy_reg));
        ev.x = VW'(ex_reg) - VW'(apx_reg);
        ev.y = VW'(ey_reg) - VW'(apy_reg);
        nc0 = (side_code == pfs_pkg::SIDE_LEFT) ? c1_reg : c0_reg;
        nc1 = (side_code == pfs_pkg::SIDE_LEFT) ? c0_reg : c1_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next = i_reg;
        lidx_next = lidx_reg;
        ridx_next = ridx_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        apx_next = apx_reg;
        apy_next = apy_reg;
        lv_next = lv_reg;
        rv_next = rv_reg;
        c0_next = c0_reg;
        c1_next = c1_reg;
        op_o_next = op_o_reg;
        op_t_next = op_t_reg;
        fresh_next = fresh_reg;
        go_next = 1'b0;
        a_next = a_reg;
        d_next = d_reg;
        res_next = res_reg;
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.cmd == pfs_pkg::CMD_QUERY)
                    begin
                        sx_next = item.ax;
                        sy_next = item.ay;
                        ex_next = item.bx;
                        ey_next = item.by;
                        count_next = '0;
                    end
                    else
                    begin
                        if (we)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (item.final_portal)
                        begin
                            state_next = ST_EMIT_START;
                        end
                    end
                end
            end
            ST_EMIT_START:
            begin
                res_next.point_x = sx_reg;
                res_next.point_y = sy_reg;
                res_next.path_end = 1'b0;
                strobe_next = 1'b1;
                apx_next = sx_reg;
                apy_next = sy_reg;
                lv_next = '0;
                rv_next = '0;
                lidx_next = '0;
                ridx_next = '0;
                fresh_next = 1'b1;
                i_next = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (i_reg < count_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    op_o_next = ev;
                    op_t_next = lv_reg;
                    go_next = 1'b1;
                    state_next = ST_END_L;
                end
            end
            ST_LOAD:
            begin
                c0_next.x = VW'(rdata.ax) - VW'(apx_reg);
                c0_next.y = VW'(rdata.ay) - VW'(apy_reg);
                c1_next.x = VW'(rdata.bx) - VW'(apx_reg);
                c1_next.y = VW'(rdata.by) - VW'(apy_reg);
                op_o_next = c0_next;
                op_t_next = c1_next;
                go_next = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                if (side_done)
                begin
                    c0_next = nc0;
                    c1_next = nc1;
                    if (fresh_reg)
                    begin
                        lv_next = nc0;
                        rv_next = nc1;
                        lidx_next = i_reg[IDX_W-1:0];
                        ridx_next = i_reg[IDX_W-1:0];
                        fresh_next = 1'b0;
                        i_next = i_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        op_o_next = nc0;
                        op_t_next = lv_reg;
                        go_next = 1'b1;
                        state_next = ST_SIDE_A;
                    end
                end
            end
            ST_SIDE_A:
            begin
                if (side_done)
                begin
                    a_next = side_code;
                    op_o_next = c1_reg;
                    op_t_next = rv_reg;
                    go_next = 1'b1;
                    state_next = ST_SIDE_D;
                end
            end
            ST_SIDE_D:
            begin
                if (side_done)
                begin
                    if ((a_reg == pfs_pkg::SIDE_RIGHT) && (side_code == pfs_pkg::SIDE_LEFT))
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        d_next = side_code;
                        op_o_next = c1_reg;
                        op_t_next = lv_reg;
                        go_next = 1'b1;
                        state_next = ST_SIDE_C;
                    end
                end
            end
            ST_SIDE_C:
            begin
                if (side_done)
                begin
                    if (side_code == pfs_pkg::SIDE_RIGHT)
                    begin
                        apx_next = lpx;
                        apy_next = lpy;
                        res_next.point_x = lpx;
                        res_next.point_y = lpy;
                        res_next.path_end = 1'b0;
                        strobe_next = 1'b1;
                        fresh_next = 1'b1;
                        i_next = CNT_W'(lidx_reg) + 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        op_o_next = c0_reg;
                        op_t_next = rv_reg;
                        go_next = 1'b1;
                        state_next = ST_SIDE_B;
                    end
                end
            end
            ST_SIDE_B:
            begin
                if (side_done)
                begin
                    if (side_code == pfs_pkg::SIDE_LEFT)
                    begin
                        apx_next = rpx;
                        apy_next = rpy;
                        res_next.point_x = rpx;
                        res_next.point_y = rpy;
                        res_next.path_end = 1'b0;
                        strobe_next = 1'b1;
                        fresh_next = 1'b1;
                        i_next = CNT_W'(ridx_reg) + 1'b1;
                    end
                    else
                    begin
                        if (a_reg == pfs_pkg::SIDE_LEFT)
                        begin
                            lv_next = c0_reg;
                            lidx_next = i_reg[IDX_W-1:0];
                        end
                        if (d_reg == pfs_pkg::SIDE_RIGHT)
                        begin
                            rv_next = c1_reg;
                            ridx_next = i_reg[IDX_W-1:0];
                        end
                        i_next = i_reg + 1'b1;
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_END_L:
            begin
                if (side_done)
                begin
                    if (side_code == pfs_pkg::SIDE_RIGHT)
                    begin
                        res_next.point_x = lpx;
                        res_next.point_y = lpy;
                        res_next.path_end = 1'b0;
                        strobe_next = 1'b1;
                        state_next = ST_EMIT_END;
                    end
                    else
                    begin
                        op_o_next = ev;
                        op_t_next = rv_reg;
                        go_next = 1'b1;
                        state_next = ST_END_R;
                    end
                end
            end
            ST_END_R:
            begin
                if (side_done)
                begin
                    if (side_code == pfs_pkg::SIDE_LEFT)
                    begin
                        res_next.point_x = rpx;
                        res_next.point_y = rpy;
                        res_next.path_end = 1'b0;
                        strobe_next = 1'b1;
                    end
                    state_next = ST_EMIT_END;
                end
            end
            ST_EMIT_END:
            begin
                res_next.point_x = ex_reg;
                res_next.point_y = ey_reg;
                res_next.path_end = 1'b1;
                strobe_next = 1'b1;
                count_next = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg <= '0;
            lidx_reg <= '0;
            ridx_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '0;
            ey_reg <= '0;
            apx_reg <= '0;
            apy_reg <= '0;
            lv_reg <= '0;
            rv_reg <= '0;
            fresh_reg <= 1'b1;
            go_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg <= i_next;
            lidx_reg <= lidx_next;
            ridx_reg <= ridx_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            apx_reg <= apx_next;
            apy_reg <= apy_next;
            lv_reg <= lv_next;
            rv_reg <= rv_next;
            fresh_reg <= fresh_next;
            go_reg <= go_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_reg <= c0_next;
        c1_reg <= c1_next;
        op_o_reg <= op_o_next;
        op_t_reg <= op_t_next;
        a_reg <= a_next;
        d_reg <= d_next;
        res_reg <= res_next;
    end
endmodule
`default_nettype wire

FILE: rtl/pfs_ram.sv
// pfs_ram: generic single write port ram with registered read
`default_nettype none
module pfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/pfs_side.sv
// pfs_side: side test of two vectors over one shared multiplier
`default_nettype none
module pfs_side (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire pfs_pkg::vec_t                   o,
    input  wire pfs_pkg::vec_t                   t,
    output logic                                 done,
    output pfs_pkg::side_t                       code
);
    typedef enum logic [2:0] {
        SD_IDLE = 3'b001,
        SD_MUL2 = 3'b010,
        SD_DONE = 3'b100
    } sd_state_t;

    sd_state_t state_reg, state_next;
    logic signed [pfs_pkg::PROD_W-1:0] p1_reg, p2_reg, prod;
    logic signed [pfs_pkg::VEC_W-1:0] mul_a, mul_b;
    logic signed [pfs_pkg::PROD_W:0] z;
    logic signed [pfs_pkg::VEC_W:0] dx, dy, adx, ady;
    logic [7:0] sqx, sqy;
    logic [8:0] sq_sum;
    logic near;

    always_comb
    begin
        mul_a = (state_reg == SD_IDLE) ? o.x : o.y;
        mul_b = (state_reg == SD_IDLE) ? t.y : t.x;
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        dx = {o.x[pfs_pkg::VEC_W-1], o.x} - {t.x[pfs_pkg::VEC_W-1], t.x};
        dy = {o.y[pfs_pkg::VEC_W-1], o.y} - {t.y[pfs_pkg::VEC_W-1], t.y};
        adx = dx[pfs_pkg::VEC_W] ? -dx : dx;
        ady = dy[pfs_pkg::VEC_W] ? -dy : dy;
        sqx = adx[3:0] * adx[3:0];
        sqy = ady[3:0] * ady[3:0];
        sq_sum = {1'b0, sqx} + {1'b0, sqy};
        near = (dx > -(pfs_pkg::VEC_W+1)'(pfs_pkg::NEAR_LIM))
            && (dx < (pfs_pkg::VEC_W+1)'(pfs_pkg::NEAR_LIM))
            && (dy > -(pfs_pkg::VEC_W+1)'(pfs_pkg::NEAR_LIM))
            && (dy < (pfs_pkg::VEC_W+1)'(pfs_pkg::NEAR_LIM))
            && (sq_sum < 9'(pfs_pkg::NEAR_SQ));
        z = {p1_reg[pfs_pkg::PROD_W-1], p1_reg} - {p2_reg[pfs_pkg::PROD_W-1], p2_reg};
        if (near)
        begin
            code = pfs_pkg::SIDE_NEAR;
        end
        else if (!z[pfs_pkg::PROD_W] && (z != '0))
        begin
            code = pfs_pkg::SIDE_LEFT;
        end
        else
        begin
            code = pfs_pkg::SIDE_RIGHT;
        end
        done = (state_reg == SD_DONE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SD_IDLE: if (start) state_next = SD_MUL2;
            SD_MUL2: state_next = SD_DONE;
            SD_DONE: state_next = SD_IDLE;
            default: state_next = SD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SD_IDLE)
        begin
            p1_reg <= prod;
        end
        if (state_reg == SD_MUL2)
        begin
            p2_reg <= prod;
        end
    end
endmodule
`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking testbench of the portal funnel path smoother (directed table, then random corridors)
module tb;
    localparam int STORE_DEPTH = 32;
    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic start;
    pfs_pkg::item_t item;
    logic busy;
    pfs_pkg::result_t result;
    logic strobe;

    portal_funnel_path_smoother_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .result(result),
        .strobe(strobe)
    );

    // path predictor state
    longint start_x, start_y, end_x, end_y;
    longint corr_ax [STORE_DEPTH];
    longint corr_ay [STORE_DEPTH];
    longint corr_bx [STORE_DEPTH];
    longint corr_by [STORE_DEPTH];
    int stored_portals;

    pfs_pkg::result_t path_points [$];
    int errors;
    int idle_cycles;

    typedef struct {
        pfs_pkg::item_t it;
        int fixed_n;
        pfs_pkg::result_t fixed [2];
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pfs_pkg::item_t mk(logic c, int ax, int ay, int bx, int by, logic fin);
        pfs_pkg::item_t t;
        t.cmd = c;
        t.ax = ax[15:0];
        t.ay = ay[15:0];
        t.bx = bx[15:0];
        t.by = by[15:0];
        t.final_portal = fin;
        return t;
    endfunction

    function automatic pfs_pkg::side_t side_of(longint ox, longint oy, longint tx, longint ty);
        longint dx, dy;
        dx = ox - tx;
        dy = oy - ty;
        if (dx > -pfs_pkg::NEAR_LIM && dx < pfs_pkg::NEAR_LIM
            && dy > -pfs_pkg::NEAR_LIM && dy < pfs_pkg::NEAR_LIM
            && dx * dx + dy * dy < pfs_pkg::NEAR_SQ)
            return pfs_pkg::SIDE_NEAR;
        return (ox * ty - oy * tx > 0) ? pfs_pkg::SIDE_LEFT : pfs_pkg::SIDE_RIGHT;
    endfunction

    function automatic pfs_pkg::result_t point(longint x, longint y, logic last);
        pfs_pkg::result_t r;
        r.point_x = x[15:0];
        r.point_y = y[15:0];
        r.path_end = last;
        return r;
    endfunction

    function automatic void queue_point(pfs_pkg::result_t p);
        path_points = {path_points, p};
    endfunction

    task automatic funnel_scan();
        longint apx, apy, lx, ly, rx, ry, c0x, c0y, c1x, c1y, tx, ty, ex, ey;
        int li, ri, i;
        bit fresh;
        pfs_pkg::side_t a, b, c, d;
        fresh = 1;
        lx = 0; ly = 0; rx = 0; ry = 0; li = 0; ri = 0;
        apx = start_x;
        apy = start_y;
        queue_point(point(apx, apy, 1'b0));
        for (i = 0; i < stored_portals; i++)
        begin
            c0x = corr_ax[i] - apx; c0y = corr_ay[i] - apy;
            c1x = corr_bx[i] - apx; c1y = corr_by[i] - apy;
            if (side_of(c0x, c0y, c1x, c1y) == pfs_pkg::SIDE_LEFT)
            begin
                tx = c0x; ty = c0y;
                c0x = c1x; c0y = c1y;
                c1x = tx; c1y = ty;
            end
            if (fresh)
            begin
                lx = c0x; ly = c0y; rx = c1x; ry = c1y;
                li = i; ri = i;
                fresh = 0;
                continue;
            end
            a = side_of(c0x, c0y, lx, ly);
            b = side_of(c0x, c0y, rx, ry);
            c = side_of(c1x, c1y, lx, ly);
            d = side_of(c1x, c1y, rx, ry);
            if (a == pfs_pkg::SIDE_RIGHT && d == pfs_pkg::SIDE_LEFT)
                continue;
            if (c == pfs_pkg::SIDE_RIGHT)
            begin
                apx += lx; apy += ly;
                queue_point(point(apx, apy, 1'b0));
                fresh = 1;
                i = li;
            end
            else if (b == pfs_pkg::SIDE_LEFT)
            begin
                apx += rx; apy += ry;
                queue_point(point(apx, apy, 1'b0));
                fresh = 1;
                i = ri;
            end
            else
            begin
                if (a == pfs_pkg::SIDE_LEFT)
                begin
                    lx = c0x; ly = c0y; li = i;
                end
                if (d == pfs_pkg::SIDE_RIGHT)
                begin
                    rx = c1x; ry = c1y; ri = i;
                end
            end
        end
        ex = end_x - apx;
        ey = end_y - apy;
        if (side_of(ex, ey, lx, ly) == pfs_pkg::SIDE_RIGHT)
            queue_point(point(lx + apx, ly + apy, 1'b0));
        else if (side_of(ex, ey, rx, ry) == pfs_pkg::SIDE_LEFT)
            queue_point(point(rx + apx, ry + apy, 1'b0));
        queue_point(point(end_x, end_y, 1'b1));
        stored_portals = 0;
    endtask

    task automatic predict(pfs_pkg::item_t t);
        if (t.cmd == pfs_pkg::CMD_QUERY)
        begin
            start_x = t.ax; start_y = t.ay;
            end_x = t.bx; end_y = t.by;
            stored_portals = 0;
            return;
        end
        if (stored_portals < STORE_DEPTH)
        begin
            corr_ax[stored_portals] = t.ax;
            corr_ay[stored_portals] = t.ay;
            corr_bx[stored_portals] = t.bx;
            corr_by[stored_portals] = t.by;
            stored_portals++;
        end
        if (t.final_portal)
            funnel_scan();
    endtask

    // drive one beat and wait until it is taken
    task automatic send(pfs_pkg::item_t t);
        start <= 1'b1;
        item <= t;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        idle_cycles = 0;
    endtask

    task automatic pause();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic int coord(int mode);
        case (mode)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 128) - 64;
            default: return $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    always @(negedge clk)
    begin
        pfs_pkg::result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                idle_cycles = 0;
                if (path_points.size() == 0)
                begin
                    $error("unexpected beat x=%0d y=%0d end=%0b",
                           result.point_x, result.point_y, result.path_end);
                    errors++;
                end
                else
                begin
                    want = path_points.pop_front();
                    if (result.point_x !== want.point_x)
                    begin
                        $error("point_x expected %0d actual %0d", want.point_x, result.point_x);
                        errors++;
                    end
                    if (result.point_y !== want.point_y)
                    begin
                        $error("point_y expected %0d actual %0d", want.point_y, result.point_y);
                        errors++;
                    end
                    if (result.path_end !== want.path_end)
                    begin
                        $error("path_end expected %0b actual %0b", want.path_end,
                               result.path_end);
                        errors++;
                    end
                end
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows [$];
        row_t r;
        pfs_pkg::item_t t;
        int n, k, mode, x0, w, step;
        errors = 0;
        idle_cycles = 0;
        stored_portals = 0;
        start_x = 0; start_y = 0; end_x = 0; end_y = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;

        r.fixed_n = 2;
        r.it = mk(pfs_pkg::CMD_PORTAL, 0, 0, 0, 0, 1'b1);
        r.fixed[0] = point(0, 0, 1'b0);
        r.fixed[1] = point(0, 0, 1'b1);
        rows = {rows, r};
        r.fixed_n = 0;
        r.it = mk(pfs_pkg::CMD_QUERY, 32767, -32768, -32768, 32767, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, -32768, -32768, 32767, 32767, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 32767, -32768, -32768, 32767, 1'b1); rows = {rows, r};
        // straight corridor
        r.it = mk(pfs_pkg::CMD_QUERY, 0, 0, 800, 0, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 100, 50, 100, -50, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 200, -50, 200, 50, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 300, 50, 300, -50, 1'b1); rows = {rows, r};
        // zigzag breaks the funnel on both sides
        r.it = mk(pfs_pkg::CMD_QUERY, 0, 0, 900, 0, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 100, 400, 100, 300, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 300, 400, 300, 300, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 500, -300, 500, -400, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 700, 400, 700, 300, 1'b1); rows = {rows, r};
        // endpoints within the near distance (16 units) of each other and of the apex
        r.it = mk(pfs_pkg::CMD_QUERY, 5, 5, 10, 10, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 5, 5, 12, 9, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 15, -1, -1, 15, 1'b1); rows = {rows, r};
        // a second query drops the stored portals
        r.it = mk(pfs_pkg::CMD_QUERY, -500, 20, 500, -20, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 0, 999, 0, 998, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_QUERY, -500, -20, 500, 20, 1'b0); rows = {rows, r};
        r.it = mk(pfs_pkg::CMD_PORTAL, 0, -100, 0, 100, 1'b1); rows = {rows, r};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[i])
        begin
            send(rows[i].it);
            if (rows[i].fixed_n > 0)
            begin
                for (int j = 0; j < rows[i].fixed_n; j++)
                    queue_point(rows[i].fixed[j]);
                stored_portals = 0;
            end
            else
            begin
                predict(rows[i].it);
            end
            pause();
        end

        n = 0;
        while (n < 250)
        begin
            k = $urandom_range(0, 11);
            if (k == 0)
            begin
                // noise beat
                t = mk(1'($urandom_range(0, 1)), coord(0), coord(0), coord(0), coord(0),
                       1'($urandom_range(0, 1)));
                send(t); predict(t); pause(); n++;
                continue;
            end
            mode = $urandom_range(0, 4);
            if (mode > 2)
                mode = 2;
            k = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 7);
            x0 = coord(1);
            step = $urandom_range(8, 300);
            w = $urandom_range(2, 200);
            t = mk(pfs_pkg::CMD_QUERY, x0, coord(1), x0 + step * (k + 1), coord(1), 1'b0);
            if (mode == 0)
                t = mk(pfs_pkg::CMD_QUERY, coord(0), coord(0), coord(0), coord(0), 1'b0);
            send(t); predict(t); pause(); n++;
            for (int j = 0; j < k; j++)
            begin
                int cy;
                cy = $urandom_range(0, 200) - 100;
                if (mode == 0)
                    t = mk(pfs_pkg::CMD_PORTAL, coord(0), coord(0), coord(0), coord(0), 1'b0);
                else if (mode == 1)
                    t = mk(pfs_pkg::CMD_PORTAL, coord(1), coord(1), coord(1), coord(1), 1'b0);
                else if ($urandom_range(0, 1))
                    t = mk(pfs_pkg::CMD_PORTAL, x0 + step * (j + 1), cy + w,
                           x0 + step * (j + 1), cy - w, 1'b0);
                else
                    t = mk(pfs_pkg::CMD_PORTAL, x0 + step * (j + 1), cy - w,
                           x0 + step * (j + 1), cy + w, 1'b0);
                t.final_portal = (j == k - 1);
                send(t); predict(t); pause(); n++;
            end
        end

        start <= 1'b0;
        while (path_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
